// File: rtl/slrd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_pkg
// Shared constants, types and the generator fold for the shuffled Lehmer draw.
// ----------------------------------------------------------------------------
package slrd_pkg;

	localparam logic [14:0] LCG_MUL   = 15'd16807;
	localparam logic [30:0] LCG_MOD   = 31'h7FFF_FFFF;
	localparam logic [31:0] RAND_TOP  = 32'h7FFF_FFFF;
	localparam int          DIV_W     = 32;
	localparam int          DIV_CNT_W = 6;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] steps;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
	} div_stat_t;

	// Reduce a 46-bit product modulo 2^31 - 1 by folding the top bits back in.
	function automatic logic [30:0] lcg_fold(input logic [45:0] prod);
		logic [31:0] sum;
		sum = 32'(prod[45:31]) + 32'(prod[30:0]);
		if (sum >= {1'b0, LCG_MOD}) begin
			sum = sum - {1'b0, LCG_MOD};
		end
		return sum[30:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/slrd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_if
// Valid/ready channels for draw requests and drawn values.
// ----------------------------------------------------------------------------
interface slrd_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;

	modport source (output valid, kind, range_low, range_high, input ready);
	modport sink (input valid, kind, range_low, range_high, output ready);
endinterface

interface slrd_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

// File: rtl/slrd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slrd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/slrd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slrd_div
// Restoring divider, one quotient bit per cycle, with a preloadable remainder.
// ----------------------------------------------------------------------------
module slrd_div import slrd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_cmd_t         cmd,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] rem_init,
	input  wire logic [DIV_W-1:0] divisor,
	output div_stat_t             stat,
	output logic      [DIV_W-1:0] remainder,
	output logic      [DIV_W-1:0] quotient
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_W-1:0]     trial;
	logic                 ge;

	// The remainder stays below the divisor, which never exceeds 2^31, so the
	// shifted trial value always fits the word.
	assign trial = {rem_q[DIV_W-2:0], dvd_q[DIV_W-1]};
	assign ge    = (trial >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= cmd.steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Quotient bits shift in at the bottom as dividend bits leave at the top.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= rem_init;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (trial - dsr_q) : trial;
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign remainder = rem_q;
	assign quotient  = dvd_q;

endmodule
`default_nettype wire

// File: rtl/shuffled_lcg_random_draw_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_lcg_random_draw_top
// Lehmer generator (16807, 2^31 - 1) behind a shuffle table, raw and ranged.
// ----------------------------------------------------------------------------
// A request on req asks for a raw draw (kind 0, value in 1..2^31-2) or a
// ranged draw (kind 1, value in [range_low, range_high] by rejection and
// modulo). One result per request leaves on rsp. Requests are taken one at a
// time; the next one is accepted while the previous result still sits in the
// output register.
// A seeded raw draw runs decode, seed check, multiply and fold overlapping
// the slot division in the serial divider, then the table read and the
// output load. The first draw after reset or after a seed write first runs
// a warm-up of multiply-and-fold steps that refill the table. A ranged draw
// adds the rejection limit and the final modulo, both bit-serial in the
// shared divider, plus a further draw for each rejected one.
// A degenerate range answers range_low straight after decode, with no draw.
// Reset clears the generator to the unseeded state and the seed to zero.
// A stalled receiver holds the result in the output register; the block
// finishes its next request and then waits until the register frees up.
// ----------------------------------------------------------------------------
module shuffled_lcg_random_draw_top import slrd_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_wr_en,
	input  wire logic [31:0] seed_wr_data,
	slrd_req_if.sink         req,
	slrd_rsp_if.source       rsp
);

	localparam int          AW       = $clog2(TABLE_DEPTH);
	localparam int          WCW      = $clog2(TABLE_DEPTH + 8);
	localparam logic [31:0] SLOT_DIV = 32'(1 + 2147483646 / TABLE_DEPTH);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LIMIT  = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_WMUL   = 4'd4;
	localparam logic [3:0] S_WFOLD  = 4'd5;
	localparam logic [3:0] S_DRAW   = 4'd6;
	localparam logic [3:0] S_DFOLD  = 4'd7;
	localparam logic [3:0] S_SLOT   = 4'd8;
	localparam logic [3:0] S_RD     = 4'd9;
	localparam logic [3:0] S_MOD    = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	logic [3:0]       state_q;
	logic [31:0]      seed_q;
	logic [30:0]      lcg_q;
	logic [30:0]      sout_q;
	logic [WCW-1:0]   wcnt_q;
	logic             rsp_valid_q;

	logic             kind_q;
	logic [31:0]      lo_q;
	logic [31:0]      diff_q;
	logic [31:0]      span_q;
	logic [31:0]      limit_q;
	logic [45:0]      mul_q;
	logic [AW-1:0]    slot_q;
	logic [31:0]      res_q;
	logic [31:0]      value_q;

	logic [30:0]      fold_v;
	logic [31:0]      seed_neg;
	logic [30:0]      seed_start;
	logic             degen;
	logic [31:0]      span_c;
	logic             reject;

	div_cmd_t         div_cmd;
	div_stat_t        div_stat;
	logic [DIV_W-1:0] div_dvd;
	logic [DIV_W-1:0] div_rem_init;
	logic [DIV_W-1:0] div_dsr;
	logic [DIV_W-1:0] div_rem;
	logic [DIV_W-1:0] div_quot;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [30:0]      ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [30:0]      ram_rdata;

	assign fold_v   = lcg_fold(mul_q);
	assign seed_neg = 32'd0 - seed_q;
	// Non-negative seeds start from one; negative ones from their negation,
	// except the two most negative, whose negation reduces to zero; these also start from one.
	assign seed_start = (seed_q[31] && (seed_q > 32'h8000_0001)) ? seed_neg[30:0] : 31'd1;
	assign degen    = (diff_q == '0) || diff_q[31];
	assign span_c   = diff_q + 32'd1;
	assign reject   = ({1'b0, ram_rdata} > limit_q);

	slrd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (div_cmd),
		.dividend  (div_dvd),
		.rem_init  (div_rem_init),
		.divisor   (div_dsr),
		.stat      (div_stat),
		.remainder (div_rem),
		.quotient  (div_quot)
	);

	slrd_ram #(
		.WIDTH (31),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		div_cmd      = '0;
		div_dvd      = '0;
		div_rem_init = '0;
		div_dsr      = span_q;
		ram_we       = 1'b0;
		ram_waddr    = wcnt_q[AW-1:0];
		ram_wdata    = fold_v;
		ram_re       = 1'b0;
		ram_raddr    = div_quot[AW-1:0];
		unique case (state_q)
			S_DECODE: begin
				// Rejection limit needs 2^31 mod span.
				if (kind_q && !degen) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = DIV_CNT_W'(DIV_W);
					div_dvd       = 32'h8000_0000;
					div_dsr       = span_c;
				end
			end
			S_WFOLD: begin
				ram_we = (wcnt_q < WCW'(TABLE_DEPTH));
			end
			S_DRAW: begin
				// The slot quotient is below TABLE_DEPTH, so only AW quotient
				// bits are developed from a preloaded partial remainder.
				div_cmd.start = 1'b1;
				div_cmd.steps = DIV_CNT_W'(AW);
				div_rem_init  = {1'b0, sout_q} >> AW;
				div_dvd       = {1'b0, sout_q} << (DIV_W - AW);
				div_dsr       = SLOT_DIV;
			end
			S_SLOT: begin
				ram_re = !div_stat.busy;
			end
			S_RD: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = lcg_q;
				if (kind_q && !reject) begin
					div_cmd.start = 1'b1;
					div_cmd.steps = DIV_CNT_W'(DIV_W);
					div_dvd       = {1'b0, ram_rdata};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= '0;
			lcg_q       <= '0;
			sout_q      <= '0;
			wcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
				lcg_q  <= '0;
				sout_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (!kind_q) begin
						state_q <= S_CHECK;
					end else if (degen) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_LIMIT;
					end
				end
				S_LIMIT: begin
					if (!div_stat.busy) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (lcg_q != '0 && sout_q != '0) begin
						state_q <= S_DRAW;
					end else begin
						lcg_q   <= seed_start;
						wcnt_q  <= WCW'(TABLE_DEPTH + 7);
						state_q <= S_WMUL;
					end
				end
				S_WMUL: begin
					state_q <= S_WFOLD;
				end
				S_WFOLD: begin
					lcg_q <= fold_v;
					if (wcnt_q == '0) begin
						sout_q  <= fold_v;
						state_q <= S_DRAW;
					end else begin
						wcnt_q  <= wcnt_q - 1'b1;
						state_q <= S_WMUL;
					end
				end
				S_DRAW: begin
					state_q <= S_DFOLD;
				end
				S_DFOLD: begin
					lcg_q   <= fold_v;
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (!div_stat.busy) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					sout_q <= ram_rdata;
					priority if (!kind_q) begin
						state_q <= S_OUT;
					end else if (reject) begin
						state_q <= S_CHECK;
					end else begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (!div_stat.busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q <= req.kind;
			lo_q   <= req.range_low;
			diff_q <= req.range_high - req.range_low;
		end
		unique case (state_q)
			S_DECODE: begin
				span_q <= span_c;
				res_q  <= lo_q;
			end
			S_LIMIT: begin
				limit_q <= RAND_TOP - div_rem;
			end
			S_WMUL, S_DRAW: begin
				mul_q <= {15'd0, lcg_q} * {31'd0, LCG_MUL};
			end
			S_SLOT: begin
				slot_q <= div_quot[AW-1:0];
			end
			S_RD: begin
				if (!kind_q) begin
					res_q <= {1'b0, ram_rdata};
				end
			end
			S_MOD: begin
				res_q <= lo_q + div_rem;
			end
			S_OUT: begin
				if (!rsp_valid_q || rsp.ready) begin
					value_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.value = value_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_draw_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DFOLD) |-> (lcg_q != '0 && sout_q != '0))
		else $error("draw started from an unseeded generator");

	a_raw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !kind_q) |->
		(res_q != '0 && !res_q[31] && res_q != RAND_TOP))
		else $error("raw draw outside 1 to 2^31-2");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_DECODE))
		else $error("accepted request not decoded");

endmodule
`default_nettype wire
